// File: hw/rtl/blru_pkg.sv
package blru_pkg;

    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_PUT = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;
    localparam logic [1:0] REQ_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [31:0] value_handle;
        logic [19:0] entry_size;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [6:0]  evicted;
        logic [26:0] bytes_used;
        logic [6:0]  entries_held;
    } rsp_t;

    // Classified command handed from the front end to the engine.
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] value;
        logic [19:0] size;
    } cmd_t;

endpackage

// File: hw/rtl/blru_front.sv
module blru_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  blru_pkg::req_t req_data,
    output logic          cmd_valid,
    input  logic          cmd_pop,
    output blru_pkg::cmd_t cmd_data
);
    import blru_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    // Classify the request; the unused code becomes an explicit no-op.
    always_comb
    begin
        cmd_in.key   = req_data.key;
        cmd_in.value = req_data.value_handle;
        cmd_in.size  = req_data.entry_size;
        unique case (req_data.req_type)
            REQ_GET: cmd_in.op = REQ_GET;
            REQ_PUT: cmd_in.op = REQ_PUT;
            REQ_DEL: cmd_in.op = REQ_DEL;
            default: cmd_in.op = REQ_NOP;
        endcase
    end

    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_data  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("command queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");

endmodule

// File: hw/rtl/blru_back.sv
module blru_back #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_budget,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  blru_pkg::cmd_t cmd_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output blru_pkg::rsp_t rsp_data
);
    import blru_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int TW = 20 + LW;
    localparam int KW = KEY_BITS;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int EW = KW + VW + 20;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUT_CHK  = 4'd1;
    localparam logic [3:0] S_PUT_EV   = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_SHD_RD   = 4'd5;
    localparam logic [3:0] S_SHD_WR   = 4'd6;
    localparam logic [3:0] S_SHU_RD   = 4'd7;
    localparam logic [3:0] S_SHU_WR   = 4'd8;
    localparam logic [3:0] S_FINAL    = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    // Entries are kept in recency order: position 0 is the most recent.
    logic [EW-1:0] mem [ENTRIES];
    logic [EW-1:0] rd_reg;

    logic [3:0]    state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [LW-1:0] cursor_reg, cursor_next;
    logic [EW-1:0] hold_reg, hold_next;
    logic [TW-1:0] total_reg, total_next;
    logic [LW-1:0] live_reg, live_next;
    logic [LW-1:0] evict_reg, evict_next;
    logic          found_reg, found_next;
    logic [31:0]   vout_reg, vout_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;
    logic [31:0]   budget_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [19:0]   rd_size;
    logic [LW-1:0] cur_inc;
    logic [LW-1:0] cur_dec;
    logic [LW-1:0] live_dec;
    logic          over_budget;
    logic          table_full;
    logic          rsp_load;

    assign rd_key   = rd_reg[EW-1 -: KW];
    assign rd_val   = rd_reg[20 +: VW];
    assign rd_size  = rd_reg[19:0];
    assign cur_inc  = cursor_reg + LW'(1);
    assign cur_dec  = cursor_reg - LW'(1);
    assign live_dec = live_reg - LW'(1);

    assign over_budget = (budget_reg != 32'd0) &&
        ((34'(total_reg) + 34'(cmd_reg.size)) > 34'(budget_reg));
    assign table_full  = (live_reg == LW'(ENTRIES));

    assign rsp_load  = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cursor_next = cursor_reg;
        hold_next   = hold_reg;
        total_next  = total_reg;
        live_next   = live_reg;
        evict_next  = evict_reg;
        found_next  = found_reg;
        vout_next   = vout_reg;
        rd_en       = 1'b0;
        rd_addr     = cursor_reg[AW-1:0];
        we          = 1'b0;
        wr_addr     = cursor_reg[AW-1:0];
        wr_data     = rd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd_data;
                    evict_next  = '0;
                    found_next  = 1'b0;
                    vout_next   = 32'd0;
                    cursor_next = '0;
                    hold_next   = {cmd_data.key[KW-1:0], cmd_data.value[VW-1:0],
                                   cmd_data.size};
                    unique case (cmd_data.op) inside
                        REQ_GET, REQ_DEL:
                            state_next = (live_reg == '0) ? S_RESP : S_SCAN_RD;
                        REQ_PUT:
                            state_next = S_PUT_CHK;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_PUT_CHK:
            begin
                if ((live_reg != '0) && (over_budget || table_full))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = live_dec[AW-1:0];
                    state_next = S_PUT_EV;
                end
                else if (live_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cursor_next = live_dec;
                    state_next  = S_SHD_RD;
                end
            end
            S_PUT_EV:
            begin
                total_next = total_reg - TW'(rd_size);
                live_next  = live_dec;
                evict_next = evict_reg + LW'(1);
                state_next = S_PUT_CHK;
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (rd_key == cmd_reg.key[KW-1:0])
                begin
                    found_next = 1'b1;
                    if (cmd_reg.op == REQ_GET)
                    begin
                        vout_next = 32'(rd_val);
                        hold_next = rd_reg;
                        if (cursor_reg == '0)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            cursor_next = cur_dec;
                            state_next  = S_SHD_RD;
                        end
                    end
                    else
                    begin
                        total_next  = total_reg - TW'(rd_size);
                        cursor_next = cur_inc;
                        state_next  = S_SHU_RD;
                    end
                end
                else if (cur_inc == live_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cursor_next = cur_inc;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHD_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SHD_WR;
            end
            S_SHD_WR:
            begin
                we      = 1'b1;
                wr_addr = cur_inc[AW-1:0];
                if (cursor_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cursor_next = cur_dec;
                    state_next  = S_SHD_RD;
                end
            end
            S_SHU_RD:
            begin
                if (cursor_reg == live_reg)
                begin
                    live_next  = live_dec;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                we          = 1'b1;
                wr_addr     = cur_dec[AW-1:0];
                cursor_next = cur_inc;
                state_next  = S_SHU_RD;
            end
            S_FINAL:
            begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = hold_reg;
                if (cmd_reg.op == REQ_PUT)
                begin
                    total_next = total_reg + TW'(cmd_reg.size);
                    live_next  = live_reg + LW'(1);
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.found        = found_reg;
        rsp_next.value_out    = vout_reg;
        rsp_next.evicted      = 7'(evict_reg);
        rsp_next.bytes_used   = 27'(total_reg);
        rsp_next.entries_held = 7'(live_reg);
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            budget_reg    <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_budget;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cursor_reg <= cursor_next;
        hold_reg   <= hold_next;
        evict_reg  <= evict_next;
        found_reg  <= found_next;
        vout_reg   <= vout_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) live_reg <= LW'(ENTRIES))
        else $error("live count above table size");
    assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == '0) |-> (total_reg == '0))
        else $error("bytes held with an empty table");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHD_WR) |-> (cursor_reg < live_reg))
        else $error("shift beyond the live entries");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> rsp_valid_reg)
        else $error("stalled result dropped");

endmodule

// File: hw/rtl/byte_budget_lru_cache.sv
// Operation: a get or delete probes entries one at a time from the most recent;
// on a hit a get moves it to the front, shifting the newer entries back, and a
// delete shifts the older ones forward. A put evicts from the oldest entry while
// needed, shifts every live entry back and writes the new one at position 0.
// The engine handles one item at a time and pulls the next command only in idle.
// Reset clears the byte and entry counts, the budget and both handshakes; entry storage is
// left as is and is only ever read below the live count.
module byte_budget_lru_cache #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  blru_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output blru_pkg::rsp_t rsp_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);
    import blru_pkg::*;

    // The front end queues and classifies each request beat; the engine pulls
    // commands from that queue and walks the recency-ordered entry memory.
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_data;

    // The budget register is always writable.
    assign cfg_ready = 1'b1;

    blru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data)
    );

    blru_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_budget (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd_data   (cmd_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

// File: verif/tb_byte_budget_lru_cache.sv
`timescale 1ns / 1ps

module tb_byte_budget_lru_cache;
    import blru_pkg::*;

    localparam int SLOTS       = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 155;
    localparam int DIR_ROWS    = 15;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    byte_budget_lru_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the cache contents. Age 0 is the most recently used
    // entry; the oldest live entry has age live_count - 1.
    logic [63:0] shadow_key   [SLOTS];
    logic [31:0] shadow_value [SLOTS];
    logic [19:0] shadow_bytes [SLOTS];
    int          shadow_age   [SLOTS];
    bit          shadow_live  [SLOTS];
    longint unsigned held_bytes;
    int          live_count;
    logic [31:0] budget_reg;

    // Responses the cache owes us, oldest first.
    rsp_t pending_rsp [$];

    int cycles;
    int mismatches;
    int items_sent;
    int rsps_seen;
    int evictions_seen;
    int hits_seen;

    // Returns the index of the youngest live entry holding the key, or -1.
    function automatic int lookup_newest(logic [63:0] k);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_live[i] && shadow_key[i] == k &&
                (best < 0 || shadow_age[i] < shadow_age[best]))
                best = i;
        end
        return best;
    endfunction

    // Drops one entry and closes the gap it leaves in the age order.
    function automatic void unlink_slot(int idx);
        int a;
        a = shadow_age[idx];
        shadow_live[idx] = 1'b0;
        held_bytes -= shadow_bytes[idx];
        live_count--;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_live[i] && shadow_age[i] > a)
                shadow_age[i]--;
        end
    endfunction

    function automatic rsp_t cache_predict(req_t r);
        rsp_t            o;
        int              h;
        int              a;
        int              ev;
        int              free_idx;
        longint unsigned limit;
        o  = '0;
        ev = 0;
        case (r.req_type)
            REQ_GET:
            begin
                h = lookup_newest(r.key);
                if (h >= 0)
                begin
                    a = shadow_age[h];
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (shadow_live[i] && shadow_age[i] < a)
                            shadow_age[i]++;
                    end
                    shadow_age[h] = 0;
                    o.found     = 1'b1;
                    o.value_out = shadow_value[h];
                end
            end
            REQ_PUT:
            begin
                // A zero budget removes the byte limit; only the slot count binds.
                limit = (budget_reg == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                          : longint'(budget_reg);
                while (live_count > 0 &&
                       (held_bytes + r.entry_size > limit || live_count >= SLOTS))
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (shadow_live[i] && shadow_age[i] == live_count - 1)
                        begin
                            unlink_slot(i);
                            break;
                        end
                    end
                    ev++;
                end
                free_idx = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!shadow_live[i])
                    begin
                        free_idx = i;
                        break;
                    end
                end
                if (free_idx >= 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (shadow_live[i])
                            shadow_age[i]++;
                    end
                    shadow_live[free_idx]  = 1'b1;
                    shadow_key[free_idx]   = r.key;
                    shadow_value[free_idx] = r.value_handle;
                    shadow_bytes[free_idx] = r.entry_size;
                    shadow_age[free_idx]   = 0;
                    held_bytes += r.entry_size;
                    live_count++;
                end
                o.evicted = ev[6:0];
            end
            REQ_DEL:
            begin
                h = lookup_newest(r.key);
                if (h >= 0)
                begin
                    unlink_slot(h);
                    o.found = 1'b1;
                end
            end
            default:
            begin
                // An unknown request leaves the cache untouched.
            end
        endcase
        o.bytes_used   = held_bytes[26:0];
        o.entries_held = live_count[6:0];
        return o;
    endfunction

    // Sender burst control: a burst of beats back to back, then a gap.
    int burst_left;

    task automatic new_burst();
        // Now and then a long stretch with no gaps at all.
        if ($urandom_range(0, 9) == 0)
            burst_left = $urandom_range(100, 300);
        else
            burst_left = $urandom_range(1, 16);
    endtask

    // Presents one request beat and holds it until the cache takes it. When
    // use_typed is set, the hand-written response is expected instead of the
    // predicted one; the predictor still runs so that its state keeps up.
    task automatic send_request(req_t r, bit use_typed, rsp_t typed_rsp);
        rsp_t predicted;
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted = cache_predict(r);
        pending_rsp.push_back(use_typed ? typed_rsp : predicted);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            new_burst();
        end
    endtask

    // Waits until every owed response has come back, then lets the engine
    // settle. The watchdog covers a response that never comes.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_budget(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        budget_reg = v;
    endtask

    // Response side: checks every accepted beat and drives its own stall
    // pattern. It switches among three modes at random: never stall, random
    // stalls, or long runs of stall.
    int stall_mode;
    int mode_left;
    int stall_run;

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsps_seen++;
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response beat: %p", rsp_data);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    evictions_seen += rsp_data.evicted;
                    hits_seen      += rsp_data.found;
                    if (rsp_data.found        !== want.found     ||
                        rsp_data.value_out    !== want.value_out ||
                        rsp_data.evicted      !== want.evicted   ||
                        rsp_data.bytes_used   !== want.bytes_used ||
                        rsp_data.entries_held !== want.entries_held)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: expected %p, got %p",
                                     rsps_seen, want, rsp_data);
                    end
                end
            end

            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (stall_run <= 0)
                        stall_run = $urandom_range(1, 24);
                    stall_run--;
                    // Long stalls, each followed by a short open window.
                    rsp_stall <= (stall_run > 3);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("byte_budget_lru_cache: mismatch");
            $finish;
        end
    end

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS];

    // Budgets per random phase: unlimited (twice), the largest value, a one-byte
    // budget, and several in between.
    logic [31:0] phase_budget [7] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd3000,
                                      32'd50000, 32'd1500000, 32'd0};
    int          phase_cap    [7] = '{2000, 60000, 20, 400, 6000, 40000, 1000};

    initial
    begin
        logic [63:0] key_pool [12];
        req_t        r;
        int          pick;
        rsp_t        none;

        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        rsp_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cycles     = 0;
        mismatches = 0;
        items_sent = 0;
        rsps_seen  = 0;
        evictions_seen = 0;
        hits_seen  = 0;
        mode_left  = 0;
        stall_run  = 0;
        held_bytes = 0;
        live_count = 0;
        budget_reg = '0;
        none       = '0;
        for (int i = 0; i < SLOTS; i++)
            shadow_live[i] = 1'b0;

        // Directed rows. Only the ones whose outcome is plain after reset are
        // typed in; the rest lean on the predictor.
        dir_rows[0]  = '{'{REQ_GET, 64'd0, 32'd0, 20'd0}, 1'b1, '0};
        dir_rows[1]  = '{'{REQ_DEL, '1, 32'd0, 20'd0}, 1'b1, '0};
        dir_rows[2]  = '{'{REQ_NOP, '1, '1, '1}, 1'b1, '0};
        dir_rows[3]  = '{'{REQ_PUT, '1, '1, '1}, 1'b1,
                         '{1'b0, 32'd0, 7'd0, 27'hFFFFF, 7'd1}};
        dir_rows[4]  = '{'{REQ_GET, '1, 32'd0, 20'd0}, 1'b1,
                         '{1'b1, '1, 7'd0, 27'hFFFFF, 7'd1}};
        // A second put of the same key shadows the first one.
        dir_rows[5]  = '{'{REQ_PUT, '1, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[6]  = '{'{REQ_GET, '1, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[7]  = '{'{REQ_DEL, '1, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[8]  = '{'{REQ_GET, '1, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[9]  = '{'{REQ_PUT, 64'd0, 32'h5A5A_5A5A, 20'd0}, 1'b0, '0};
        dir_rows[10] = '{'{REQ_PUT, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5, 20'd1},
                         1'b0, '0};
        dir_rows[11] = '{'{REQ_GET, 64'd0, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[12] = '{'{REQ_DEL, 64'd0, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[13] = '{'{REQ_DEL, 64'd0, 32'd0, 20'd0}, 1'b0, '0};
        dir_rows[14] = '{'{REQ_NOP, 64'h8000_0000_0000_0000, 32'd0, 20'd0}, 1'b0, '0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        new_burst();

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            write_budget(phase_budget[p]);
            for (int k = 0; k < 12; k++)
                key_pool[k] = {$urandom(), $urandom()};
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    r.req_type = REQ_PUT;
                else if (pick < 80)
                    r.req_type = REQ_GET;
                else if (pick < 95)
                    r.req_type = REQ_DEL;
                else
                    r.req_type = REQ_NOP;
                // Mostly keys from a small pool so that hits, shadowing and
                // deletes happen; the rest are fresh keys that miss.
                if ($urandom_range(0, 99) < 85)
                    r.key = key_pool[$urandom_range(0, 11)];
                else
                    r.key = {$urandom(), $urandom()};
                r.value_handle = $urandom();
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    r.entry_size = 20'($urandom_range(0, 20'hFFFFF));
                else if (pick < 8)
                    r.entry_size = $urandom_range(0, 1) ? 20'hFFFFF : 20'd0;
                else
                    r.entry_size = 20'($urandom_range(0, phase_cap[p]));
                send_request(r, 1'b0, none);
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("%0d requests over 7 budget settings, %0d responses, %0d hits, %0d evictions",
                 items_sent, rsps_seen, hits_seen, evictions_seen);
        $display("%0d mismatching responses, %0d left owed", mismatches, pending_rsp.size());
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("byte_budget_lru_cache: match");
        else
            $display("byte_budget_lru_cache: mismatch");
        $finish;
    end

endmodule
